>>> src/lmbg_pkg.sv
// Package for the lane multiplicative generator: payload structs, state codes,
// register and request codes, and the constant functions that build the jump table.
// No dependencies.
`default_nettype none

package lmbg_pkg;

    // generator constants
    localparam int unsigned LANES_DEF = 16;
    localparam int unsigned WORD_W    = 31;
    localparam int unsigned SKIP_W    = 21;
    localparam int unsigned JUMP_W    = $clog2(SKIP_W);
    localparam logic [WORD_W-1:0] MULT_BASE = 31'd48271;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SKIP_W-1:0][WORD_W-1:0] jump_tab_t;

    // request kinds
    localparam logic [1:0] REQ_RESEED = 2'd0;
    localparam logic [1:0] REQ_SKIP   = 2'd1;
    localparam logic [1:0] REQ_DRAW   = 2'd2;

    // register indexes
    localparam logic REG_SEED   = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // register reset values
    localparam word_t SEED_RST   = 31'd1;
    localparam word_t THRESH_RST = 31'd1073741823;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [20:0] skip_count;
        logic [4:0]  lane_count;
    } in_item_t;

    typedef struct packed {
        logic [15:0] outcome_bits;
        logic [1:0]  done_kind;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_JUMP,
        ST_SCALE,
        ST_DONE
    } state_t;

    // product modulo 2^31
    function automatic word_t mul_low(input word_t a, input word_t b);
        logic [2*WORD_W-1:0] p;
        p = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        return p[WORD_W-1:0];
    endfunction

    // base raised to e, evaluated at elaboration
    function automatic word_t pow_base(input int unsigned e);
        word_t acc;
        acc = 31'd1;
        for (int unsigned i = 0; i < e; i++)
        begin
            acc = mul_low(acc, MULT_BASE);
        end
        return acc;
    endfunction

    // table of base^(2^i), evaluated at elaboration
    function automatic jump_tab_t build_jump_table();
        jump_tab_t tab;
        word_t     m;
        m = MULT_BASE;
        for (int unsigned i = 0; i < SKIP_W; i++)
        begin
            tab[i] = m;
            m = mul_low(m, m);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

>>> src/lane_mcg_bernoulli_generator.sv
// Top level of the lane multiplicative generator with Bernoulli draws.
// Depends on lmbg_pkg for payload structs, state codes and constant tables.
`default_nettype none

// LANES generator lanes, each a 31-bit state stepped by x = 48271*x mod 2^31, kept in
// a one-read one-write lane memory with registered read. One item is handled at a time;
// the length of each pass is set by the single shared 31x31 multiplier, which handles
// one lane or one jump-table bit per cycle, and by the memory's one read port. A skip
// first folds 48271^skip_count over the 21 count bits, then scales every lane. After
// reset a load pass writes 48271^k into lane k, with in_ready low. A finished result
// waits in an output register while the next item is taken.
module lane_mcg_bernoulli_generator #(
    parameter int unsigned LANES = lmbg_pkg::LANES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lmbg_pkg::in_item_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lmbg_pkg::out_item_t       out_item,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int unsigned CNT_W = $clog2(LANES + 1);
    localparam logic [4:0]  WantMax = 5'((LANES < 16) ? LANES : 16);
    localparam lmbg_pkg::word_t    DrawMult = lmbg_pkg::pow_base(LANES);
    localparam lmbg_pkg::jump_tab_t JumpTab = lmbg_pkg::build_jump_table();

    lmbg_pkg::state_t state_reg, state_next;

    lmbg_pkg::word_t seed_reg, thresh_reg;
    lmbg_pkg::word_t v_reg, v_next;
    lmbg_pkg::word_t m_reg, m_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [lmbg_pkg::JUMP_W-1:0] j_reg, j_next;
    logic [lmbg_pkg::SKIP_W-1:0] skip_reg, skip_next;
    logic [1:0]  kind_reg, kind_next;
    logic [4:0]  want_reg, want_next;
    logic        init_reg, init_next;
    logic        p1_valid_reg, p1_valid_next;
    logic [IDX_W-1:0] p1_idx_reg, p1_idx_next;
    logic        p2_valid_reg, p2_valid_next;
    logic [IDX_W-1:0] p2_idx_reg, p2_idx_next;
    lmbg_pkg::word_t p2_prod_reg, p2_prod_next;
    logic [15:0] bits_reg, bits_next;
    logic        out_valid_reg, out_valid_next;
    lmbg_pkg::out_item_t out_item_reg, out_item_next;

    // lane memory
    lmbg_pkg::word_t lane_mem [LANES];
    lmbg_pkg::word_t rdata_reg;
    logic            mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    lmbg_pkg::word_t mem_wdata;

    // shared multiplier
    lmbg_pkg::word_t mult_a, mult_b, prod;

    logic in_accept;
    logic slot_free;
    logic load_last, jump_last, scale_last, rd_go;
    logic cfg_we;
    logic [3:0] bit_pos;

    assign in_accept  = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign load_last  = (idx_reg == CNT_W'(LANES - 1));
    assign jump_last  = (j_reg == lmbg_pkg::JUMP_W'(lmbg_pkg::SKIP_W - 1));
    assign rd_go      = (state_reg == lmbg_pkg::ST_SCALE) && (rd_cnt_reg < CNT_W'(LANES));
    assign scale_last = (rd_cnt_reg == CNT_W'(LANES)) && !p1_valid_reg && !p2_valid_reg;
    assign prod       = lmbg_pkg::mul_low(mult_a, mult_b);
    assign bit_pos    = 4'(p2_idx_reg);

    // configuration port
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            lmbg_pkg::REG_SEED:   prdata = {1'b0, seed_reg};
            lmbg_pkg::REG_THRESH: prdata = {1'b0, thresh_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= lmbg_pkg::SEED_RST;
            thresh_reg <= lmbg_pkg::THRESH_RST;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == lmbg_pkg::REG_SEED)
            begin
                seed_reg <= pwdata[30:0];
            end
            else
            begin
                thresh_reg <= pwdata[30:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmbg_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_item.req_type)
                        lmbg_pkg::REQ_RESEED: state_next = lmbg_pkg::ST_LOAD;
                        lmbg_pkg::REQ_SKIP:   state_next = lmbg_pkg::ST_JUMP;
                        lmbg_pkg::REQ_DRAW:   state_next = lmbg_pkg::ST_SCALE;
                        default:              state_next = lmbg_pkg::ST_IDLE;
                    endcase
                end
            end
            lmbg_pkg::ST_LOAD:
            begin
                if (load_last)
                begin
                    state_next = init_reg ? lmbg_pkg::ST_IDLE : lmbg_pkg::ST_DONE;
                end
            end
            lmbg_pkg::ST_JUMP:
            begin
                if (jump_last)
                begin
                    state_next = lmbg_pkg::ST_SCALE;
                end
            end
            lmbg_pkg::ST_SCALE:
            begin
                if (scale_last)
                begin
                    state_next = lmbg_pkg::ST_DONE;
                end
            end
            lmbg_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = lmbg_pkg::ST_IDLE;
                end
            end
            default: state_next = lmbg_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready       = 1'b0;
        v_next         = v_reg;
        m_next         = m_reg;
        idx_next       = idx_reg;
        rd_cnt_next    = rd_cnt_reg;
        j_next         = j_reg;
        skip_next      = skip_reg;
        kind_next      = kind_reg;
        want_next      = want_reg;
        init_next      = init_reg;
        p1_valid_next  = 1'b0;
        p1_idx_next    = rd_cnt_reg[IDX_W-1:0];
        p2_valid_next  = p1_valid_reg;
        p2_idx_next    = p1_idx_reg;
        p2_prod_next   = prod;
        bits_next      = bits_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        mult_a         = v_reg;
        mult_b         = lmbg_pkg::MULT_BASE;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IDX_W-1:0];
        mem_wdata      = v_reg;
        mem_raddr      = rd_cnt_reg[IDX_W-1:0];
        case (state_reg)
            lmbg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_accept)
                begin
                    kind_next   = in_item.req_type;
                    bits_next   = '0;
                    idx_next    = '0;
                    rd_cnt_next = '0;
                    j_next      = '0;
                    init_next   = 1'b0;
                    skip_next   = in_item.skip_count;
                    want_next   = '0;
                    v_next      = (seed_reg == '0) ? 31'd1 : seed_reg;
                    m_next      = 31'd1;
                    if (in_item.req_type == lmbg_pkg::REQ_DRAW)
                    begin
                        m_next    = DrawMult;
                        want_next = (in_item.lane_count > WantMax) ? WantMax
                                                                   : in_item.lane_count;
                    end
                end
            end
            lmbg_pkg::ST_LOAD:
            begin
                // write one lane, step the running power
                mem_we   = 1'b1;
                v_next   = prod;
                idx_next = idx_reg + CNT_W'(1);
            end
            lmbg_pkg::ST_JUMP:
            begin
                // fold one count bit into the jump multiplier
                mult_a = m_reg;
                mult_b = JumpTab[j_reg];
                if (skip_reg[j_reg])
                begin
                    m_next = prod;
                end
                j_next = j_reg + lmbg_pkg::JUMP_W'(1);
            end
            lmbg_pkg::ST_SCALE:
            begin
                // read, multiply, write back, one lane per cycle
                mult_a        = rdata_reg;
                mult_b        = m_reg;
                p1_valid_next = rd_go;
                if (rd_go)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (p2_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = p2_idx_reg;
                    mem_wdata = p2_prod_reg;
                    if ((7'(p2_idx_reg) < 7'(want_reg)) && (p2_prod_reg <= thresh_reg))
                    begin
                        bits_next[bit_pos] = 1'b1;
                    end
                end
            end
            lmbg_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.outcome_bits = bits_reg;
                    out_item_next.done_kind    = kind_reg;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmbg_pkg::ST_LOAD;
            init_reg      <= 1'b1;
            v_reg         <= 31'd1;
            idx_reg       <= '0;
            rd_cnt_reg    <= '0;
            j_reg         <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            v_reg         <= v_next;
            idx_reg       <= idx_next;
            rd_cnt_reg    <= rd_cnt_next;
            j_reg         <= j_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        skip_reg     <= skip_next;
        kind_reg     <= kind_next;
        want_reg     <= want_next;
        p1_idx_reg   <= p1_idx_next;
        p2_idx_reg   <= p2_idx_next;
        p2_prod_reg  <= p2_prod_next;
        bits_reg     <= bits_next;
        out_item_reg <= out_item_next;
    end

    // lane memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lane_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= lane_mem[mem_raddr];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    // lane memory is only written during a load or scale pass
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == lmbg_pkg::ST_LOAD || state_reg == lmbg_pkg::ST_SCALE))
        else $error("lane memory written outside a pass");

    // a blocked result keeps the finished item waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmbg_pkg::ST_DONE && out_valid_reg && !out_ready)
        |=> state_reg == lmbg_pkg::ST_DONE)
        else $error("result dropped while output register full");

    // scale pipeline drains before the pass ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg || p2_valid_reg) |-> state_reg == lmbg_pkg::ST_SCALE)
        else $error("scale pipeline active outside scale pass");

    // read counter never passes the lane count
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CNT_W'(LANES))
        else $error("lane read counter overran");
`endif

endmodule

`default_nettype wire
